// ===== hw/rtl/stt_pkg.sv =====
// Shared types, constants and character classes for the source text tokenizer.
// Used by stt_res_queue and source_text_tokenizer_unit; depends on nothing.

package stt_pkg;

  // Token length limit and widths
  localparam int unsigned MaxLen       = 127;
  localparam int unsigned LenW         = 7;
  localparam int unsigned WindowLen    = 6;
  localparam int unsigned NumWords     = 7;
  localparam int unsigned KeywordCount = 7;
  localparam int unsigned WordW        = 48;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned SlotW        = 3;

  // Result queue depth; room for two results must remain to accept a byte
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueuePtrW    = $clog2(QueueDepth);
  localparam int unsigned QueueCntW    = $clog2(QueueDepth + 1);

  // Keyword words after reset
  localparam logic [NumWords-1:0][WordW-1:0] KeywordReset = '{
    48'd6975321,
    48'd435610544247,
    48'd121437875889522,
    48'd1702063205,
    48'd26217,
    48'd499850898534,
    48'd7630441
  };

  typedef enum logic [2:0] {
    KindKeyword  = 3'd0,
    KindIdent    = 3'd1,
    KindNumber   = 3'd2,
    KindOperator = 3'd3,
    KindPunct    = 3'd4,
    KindError    = 3'd5
  } token_kind_e;

  typedef enum logic [1:0] {
    ModeIdle   = 2'd0,
    ModeIdent  = 2'd1,
    ModeNumber = 2'd2
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_req_t;

  typedef struct packed {
    logic [2:0]      token_kind;
    logic [SlotW-1:0] keyword_slot;
    logic [LenW-1:0] token_length;
    logic            length_overflow;
    logic [7:0]      first_char;
    logic            last_of_run;
  } out_res_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic logic is_under(logic [7:0] c);
    return c == 8'd95;
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return (c == 8'd43) || (c == 8'd45) || (c == 8'd42) || (c == 8'd47) ||
           (c == 8'd61) || (c == 8'd60) || (c == 8'd62);
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return (c == 8'd59) || (c == 8'd44) || (c == 8'd40) || (c == 8'd41) ||
           (c == 8'd123) || (c == 8'd125);
  endfunction

endpackage

// ===== hw/rtl/stt_res_queue.sv =====
// Result queue for the tokenizer: takes up to two results a cycle, gives one unless stalled.
// Depends on stt_pkg.

module stt_res_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [1:0]                        push_cnt_i,
  input  stt_pkg::out_res_t                 push0_res_i,
  input  stt_pkg::out_res_t                 push1_res_i,
  output logic                              almost_full_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output stt_pkg::out_res_t                 out_res_o
);

  stt_pkg::out_res_t                     mem_q [stt_pkg::QueueDepth];
  logic [stt_pkg::QueuePtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [stt_pkg::QueuePtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [stt_pkg::QueuePtrW-1:0]         wr_ptr_nx;
  logic [stt_pkg::QueueCntW-1:0]         cnt_q, cnt_d;
  logic                                  pop;

  assign out_valid_o   = (cnt_q != '0);
  assign out_res_o     = mem_q[rd_ptr_q];
  assign almost_full_o = (cnt_q > stt_pkg::QueueCntW'(stt_pkg::QueueDepth - 2));
  assign pop           = out_valid_o && !out_stall_i;
  assign wr_ptr_nx     = wr_ptr_q + 1'b1;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q + stt_pkg::QueuePtrW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + stt_pkg::QueuePtrW'(pop);
    cnt_d    = cnt_q + stt_pkg::QueueCntW'(push_cnt_i) - stt_pkg::QueueCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store incoming results in order
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_res_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= push1_res_i;
    end
  end

  // Occupancy never exceeds the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= stt_pkg::QueueCntW'(stt_pkg::QueueDepth))
    else $error("result queue over capacity");

  // No push lands on a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i != 2'd0) |-> !almost_full_o)
    else $error("push while queue lacks room");

  // Pointers differ by the occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stt_pkg::QueuePtrW'(wr_ptr_q - rd_ptr_q) == stt_pkg::QueuePtrW'(cnt_q))
    else $error("queue pointers out of step with count");

endmodule

// ===== hw/rtl/source_text_tokenizer_unit.sv =====
// Top level of the streaming source text tokenizer: scanner state, keyword
// registers and compare, feeding the result queue. Depends on stt_pkg, stt_res_queue.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | request   | in_valid_i/in_stall_o  | in_req_i (byte, end of text)
//  out     | result    | out_valid_o/out_stall_i| out_res_o (one token)
//  cfg     | write     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One byte is taken per cycle unless the input stalls; it gives zero, one or two
// results that enter a four-deep result queue in the same cycle and leave it one
// per cycle unless the output stalls. The result queue sets the rate: input stalls
// while fewer than two entries are free. Results reach the output in queue order.
// Reset restores the keyword words and empties the scanner and the queue.

module source_text_tokenizer_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  stt_pkg::in_req_t                   in_req_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output stt_pkg::out_res_t                  out_res_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [stt_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [stt_pkg::WordW-1:0]          cfg_data_i
);

  logic [stt_pkg::NumWords-1:0][stt_pkg::WordW-1:0]  kw_q;
  stt_pkg::scan_mode_e                               mode_q, mode_d, post_mode;
  logic [stt_pkg::LenW-1:0]                          len_q, len_d, post_len, src_len;
  logic                                              ovf_q, ovf_d, post_ovf, src_ovf;
  logic [7:0]                                        first_q, first_d, post_first;
  logic [stt_pkg::WindowLen-1:0][7:0]                win_q, win_d, post_win, src_win;

  logic [7:0]                 c;
  logic                       accept, almost_full;
  logic                       c_alpha, c_digit;
  logic                       taken, has_a, has_b, has_e;
  logic                       kw_hit;
  logic [stt_pkg::SlotW-1:0]  kw_slot;
  logic [1:0]                 n_res, push_cnt;
  stt_pkg::out_res_t          res_a, res_b, res_e, push0, push1;

  assign c           = in_req_i.text_byte;
  assign c_alpha     = stt_pkg::is_alpha(c);
  assign c_digit     = stt_pkg::is_digit(c);
  assign in_stall_o  = almost_full;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Keyword word registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kw_q <= stt_pkg::KeywordReset;
    end else if (cfg_valid_i && cfg_ready_o &&
                 (cfg_index_i < stt_pkg::CfgIdxW'(stt_pkg::NumWords))) begin
      kw_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Continue, close or start the pending token
  always_comb begin
    taken = ((mode_q == stt_pkg::ModeIdent) && (c_alpha || c_digit || stt_pkg::is_under(c))) ||
            ((mode_q == stt_pkg::ModeNumber) && c_digit);
    has_a = ((mode_q == stt_pkg::ModeIdent) || (mode_q == stt_pkg::ModeNumber)) && !taken;
    has_b = !taken && !stt_pkg::is_space(c) && !c_alpha && !c_digit;

    post_mode  = stt_pkg::ModeIdle;
    post_len   = '0;
    post_ovf   = 1'b0;
    post_first = '0;
    post_win   = '0;
    if (taken) begin
      post_mode  = mode_q;
      post_first = first_q;
      post_win   = win_q;
      for (int i = 0; i < stt_pkg::WindowLen; i++) begin
        if (len_q == stt_pkg::LenW'(i)) begin
          post_win[i] = c;
        end
      end
      if (len_q < stt_pkg::LenW'(stt_pkg::MaxLen)) begin
        post_len = len_q + 1'b1;
        post_ovf = ovf_q;
      end else begin
        post_len = len_q;
        post_ovf = 1'b1;
      end
    end else if (c_alpha || c_digit) begin
      post_mode   = c_alpha ? stt_pkg::ModeIdent : stt_pkg::ModeNumber;
      post_len    = stt_pkg::LenW'(1);
      post_first  = c;
      post_win[0] = c;
    end

    has_e = in_req_i.end_of_text && (post_mode != stt_pkg::ModeIdle);

    // Flush on end of text, else hold the updated token
    if (has_e) begin
      mode_d  = stt_pkg::ModeIdle;
      len_d   = '0;
      ovf_d   = 1'b0;
      first_d = '0;
      win_d   = '0;
    end else begin
      mode_d  = post_mode;
      len_d   = post_len;
      ovf_d   = post_ovf;
      first_d = post_first;
      win_d   = post_win;
    end
  end

  // Only one identifier can close per byte: compare the one that does
  always_comb begin
    if (has_a && (mode_q == stt_pkg::ModeIdent)) begin
      src_win = win_q;
      src_len = len_q;
      src_ovf = ovf_q;
    end else begin
      src_win = post_win;
      src_len = post_len;
      src_ovf = post_ovf;
    end
    kw_hit  = 1'b0;
    kw_slot = '0;
    if (!src_ovf && (src_len <= stt_pkg::LenW'(stt_pkg::WindowLen))) begin
      for (int i = stt_pkg::KeywordCount - 1; i >= 0; i--) begin
        if ((kw_q[i] != '0) && (kw_q[i] == src_win)) begin
          kw_hit  = 1'b1;
          kw_slot = stt_pkg::SlotW'(i);
        end
      end
    end
  end

  // Build the closed, single-character and flushed results
  always_comb begin
    res_a.token_kind      = stt_pkg::KindNumber;
    res_a.keyword_slot    = '0;
    if (mode_q == stt_pkg::ModeIdent) begin
      res_a.token_kind    = kw_hit ? stt_pkg::KindKeyword : stt_pkg::KindIdent;
      res_a.keyword_slot  = kw_hit ? kw_slot : '0;
    end
    res_a.token_length    = len_q;
    res_a.length_overflow = ovf_q;
    res_a.first_char      = first_q;
    res_a.last_of_run     = 1'b0;

    if (stt_pkg::is_op(c)) begin
      res_b.token_kind    = stt_pkg::KindOperator;
    end else if (stt_pkg::is_punct(c)) begin
      res_b.token_kind    = stt_pkg::KindPunct;
    end else begin
      res_b.token_kind    = stt_pkg::KindError;
    end
    res_b.keyword_slot    = '0;
    res_b.token_length    = stt_pkg::LenW'(1);
    res_b.length_overflow = 1'b0;
    res_b.first_char      = c;
    res_b.last_of_run     = 1'b0;

    res_e.token_kind      = stt_pkg::KindNumber;
    res_e.keyword_slot    = '0;
    if (post_mode == stt_pkg::ModeIdent) begin
      res_e.token_kind    = kw_hit ? stt_pkg::KindKeyword : stt_pkg::KindIdent;
      res_e.keyword_slot  = kw_hit ? kw_slot : '0;
    end
    res_e.token_length    = post_len;
    res_e.length_overflow = post_ovf;
    res_e.first_char      = post_first;
    res_e.last_of_run     = 1'b0;

    // Order: closed token first, then the byte's own token or the flush
    push0 = has_a ? res_a : (has_b ? res_b : res_e);
    push1 = has_b ? res_b : res_e;
    push0.last_of_run = !(has_a && (has_b || has_e));
    push1.last_of_run = 1'b1;
    n_res    = {1'b0, has_a} + {1'b0, has_b || has_e};
    push_cnt = accept ? n_res : 2'd0;
  end

  // Scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= stt_pkg::ModeIdle;
      len_q   <= '0;
      ovf_q   <= 1'b0;
      first_q <= '0;
      win_q   <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      first_q <= first_d;
      win_q   <= win_d;
    end
  end

  stt_res_queue u_res_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_cnt_i    (push_cnt),
    .push0_res_i   (push0),
    .push1_res_i   (push1),
    .almost_full_o (almost_full),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_res_o     (out_res_o)
  );

  // An idle scanner holds no length; a pending token holds at least one byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == stt_pkg::ModeIdle) == (len_q == '0))
    else $error("pending length disagrees with scan mode");

  // Overflow only once the length sits at its limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (len_q == stt_pkg::LenW'(stt_pkg::MaxLen)))
    else $error("overflow flag below length limit");

  // An accepted end-of-text byte leaves the scanner idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_req_i.end_of_text) |=> (mode_q == stt_pkg::ModeIdle))
    else $error("pending token survived end of text");

endmodule

// ===== sim/source_text_tokenizer_unit_test.sv =====
// Self-checking bench for source_text_tokenizer_unit: byte stream in, tokens out.
// Depends on stt_pkg and the tokenizer top level; tokens are predicted from
// a behavioral scanner kept in step with every accepted request.

module source_text_tokenizer_unit_test;

  localparam int Limit = 200000;

  typedef enum {ChBlank, ChLetter, ChDigit, ChUnder, ChOp, ChPunct, ChOther} char_class_e;

  // Directed stimulus row: byte, end flag and an optional typed-in token
  typedef struct packed {
    logic [7:0]        b;
    logic              eot;
    logic              typed;
    stt_pkg::out_res_t res;
  } probe_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  stt_pkg::in_req_t  in_req = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  stt_pkg::out_res_t out_res;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [47:0]       cfg_data = '0;

  int    cycles = 0;
  int    errors = 0;
  int    sent = 0;
  bit    calm = 1'b0;
  string symbols = "+-*/=<>;,(){}";

  // Scanner copy and the tokens still owed by the block
  stt_pkg::scan_mode_e                                scan = stt_pkg::ModeIdle;
  logic [stt_pkg::LenW-1:0]                           tok_len = '0;
  logic                                               tok_ovf = 1'b0;
  logic [7:0]                                         tok_first = '0;
  logic [stt_pkg::WindowLen-1:0][7:0]                 tok_head = '0;
  logic [stt_pkg::NumWords-1:0][stt_pkg::WordW-1:0]   kw_words = stt_pkg::KeywordReset;
  stt_pkg::out_res_t                                  awaited_tokens[$];
  probe_t                                             directed[$];

  source_text_tokenizer_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_res_o  (out_res),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
  endtask

  // ---------------------------------------------------------------- scanner

  function automatic char_class_e classify(logic [7:0] c);
    if (c == " " || (c >= 8'h09 && c <= 8'h0d)) return ChBlank;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return ChLetter;
    if (c >= "0" && c <= "9") return ChDigit;
    if (c == "_") return ChUnder;
    case (c)
      "+", "-", "*", "/", "=", "<", ">": return ChOp;
      ";", ",", "(", ")", "{", "}":      return ChPunct;
      default:                           return ChOther;
    endcase
  endfunction

  function automatic void push_token(stt_pkg::token_kind_e k, logic [2:0] s,
                                     logic [stt_pkg::LenW-1:0] len, logic ovf,
                                     logic [7:0] c);
    stt_pkg::out_res_t t;
    t.token_kind      = k;
    t.keyword_slot    = s;
    t.token_length    = len;
    t.length_overflow = ovf;
    t.first_char      = c;
    t.last_of_run     = 1'b0;
    awaited_tokens.push_back(t);
  endfunction

  function automatic void open_token(stt_pkg::scan_mode_e m, logic [7:0] c);
    scan      = m;
    tok_len   = 7'd1;
    tok_ovf   = 1'b0;
    tok_first = c;
    tok_head  = '0;
    tok_head[0] = c;
  endfunction

  function automatic void grow_token(logic [7:0] c);
    if (tok_len < stt_pkg::WindowLen) tok_head[tok_len[2:0]] = c;
    if (tok_len < stt_pkg::MaxLen) tok_len = tok_len + 1'b1;
    else tok_ovf = 1'b1;
  endfunction

  // Close the pending word; short identifiers try the keywords, lowest slot wins
  function automatic void close_token();
    stt_pkg::token_kind_e k;
    logic [2:0]           s;
    int                   i;
    k = (scan == stt_pkg::ModeIdent) ? stt_pkg::KindIdent : stt_pkg::KindNumber;
    s = '0;
    if (scan == stt_pkg::ModeIdent && !tok_ovf && tok_len <= stt_pkg::WindowLen) begin
      for (i = stt_pkg::KeywordCount - 1; i >= 0; i--) begin
        if (kw_words[i] != '0 && kw_words[i] == tok_head) begin
          k = stt_pkg::KindKeyword;
          s = 3'(i);
        end
      end
    end
    push_token(k, s, tok_len, tok_ovf, tok_first);
    scan      = stt_pkg::ModeIdle;
    tok_len   = '0;
    tok_ovf   = 1'b0;
    tok_first = '0;
    tok_head  = '0;
  endfunction

  function automatic void tokenize_byte(stt_pkg::in_req_t r);
    char_class_e cc;
    bit          taken;
    int          n;
    cc    = classify(r.text_byte);
    taken = 1'b0;
    n     = 0;
    if (scan == stt_pkg::ModeIdent) begin
      if (cc == ChLetter || cc == ChDigit || cc == ChUnder) begin
        grow_token(r.text_byte);
        taken = 1'b1;
      end else begin
        close_token();
        n++;
      end
    end else if (scan == stt_pkg::ModeNumber) begin
      if (cc == ChDigit) begin
        grow_token(r.text_byte);
        taken = 1'b1;
      end else begin
        close_token();
        n++;
      end
    end
    if (!taken) begin
      case (cc)
        ChBlank: begin
        end
        ChLetter: open_token(stt_pkg::ModeIdent, r.text_byte);
        ChDigit:  open_token(stt_pkg::ModeNumber, r.text_byte);
        ChOp: begin
          push_token(stt_pkg::KindOperator, '0, 7'd1, 1'b0, r.text_byte);
          n++;
        end
        ChPunct: begin
          push_token(stt_pkg::KindPunct, '0, 7'd1, 1'b0, r.text_byte);
          n++;
        end
        default: begin
          push_token(stt_pkg::KindError, '0, 7'd1, 1'b0, r.text_byte);
          n++;
        end
      endcase
    end
    // flush whatever is still open at end of text
    if (r.end_of_text && scan != stt_pkg::ModeIdle) begin
      close_token();
      n++;
    end
    if (n > 0) awaited_tokens[awaited_tokens.size() - 1].last_of_run = 1'b1;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Offer one request; hold it until accepted, then predict its tokens
  task automatic send_byte(logic [7:0] b, logic eot, logic typed, stt_pkg::out_res_t want);
    stt_pkg::in_req_t r;
    int               held;
    r.text_byte   = b;
    r.end_of_text = eot;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    held = awaited_tokens.size();
    tokenize_byte(r);
    if (typed) begin
      while (awaited_tokens.size() > held) void'(awaited_tokens.pop_back());
      awaited_tokens.push_back(want);
    end
  endtask

  task automatic put(logic [7:0] b);
    send_byte(b, $urandom_range(99) < 4, 1'b0, '0);
  endtask

  task automatic write_word(logic [2:0] idx, logic [47:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < stt_pkg::NumWords) kw_words[idx] = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and wait for the block to drain before touching registers
  task automatic settle();
    int k;
    @(negedge clk);
    in_valid <= 1'b0;
    for (k = 0; k < 2000 && awaited_tokens.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- text

  function automatic logic [7:0] letter();
    int r;
    r = $urandom_range(51);
    return (r < 26) ? 8'(65 + r) : 8'(97 + r - 26);
  endfunction

  function automatic logic [7:0] ident_char();
    int r;
    r = $urandom_range(63);
    if (r < 52) return letter();
    if (r < 62) return 8'(48 + r - 52);
    return 8'h5f;
  endfunction

  function automatic logic [7:0] blank();
    int p;
    p = $urandom_range(5);
    return (p == 5) ? 8'h20 : 8'(9 + p);
  endfunction

  function automatic logic [7:0] digit();
    return 8'(48 + $urandom_range(9));
  endfunction

  function automatic logic [47:0] make_word(int len);
    logic [47:0] w;
    int          i;
    w = '0;
    w[7:0] = letter();
    for (i = 1; i < len; i++) w[8*i +: 8] = ident_char();
    return w;
  endfunction

  function automatic stt_pkg::out_res_t tok(stt_pkg::token_kind_e k, logic [2:0] s,
                                            logic [stt_pkg::LenW-1:0] len, logic [7:0] c);
    stt_pkg::out_res_t t;
    t.token_kind      = k;
    t.keyword_slot    = s;
    t.token_length    = len;
    t.length_overflow = 1'b0;
    t.first_char      = c;
    t.last_of_run     = 1'b1;
    return t;
  endfunction

  function automatic probe_t row(logic [7:0] b, logic eot, logic typed,
                                 stt_pkg::out_res_t res);
    probe_t p;
    p.b     = b;
    p.eot   = eot;
    p.typed = typed;
    p.res   = res;
    return p;
  endfunction

  // One random token, mostly well formed, then maybe a separator
  task automatic emit_token();
    int          pick;
    int          len;
    int          i;
    logic [47:0] w;
    pick = $urandom_range(99);
    if (pick < 15) begin
      w = kw_words[$urandom_range(stt_pkg::NumWords - 1)];
      for (i = 0; i < stt_pkg::WindowLen; i++) begin
        if (w[8*i +: 8] != 8'h00) put(w[8*i +: 8]);
      end
      if ($urandom_range(3) == 0) put(ident_char());
    end else if (pick < 35) begin
      len = $urandom_range(1, 8);
      put(letter());
      for (i = 1; i < len; i++) put(ident_char());
    end else if (pick < 50) begin
      len = $urandom_range(1, 5);
      for (i = 0; i < len; i++) put(digit());
    end else if (pick < 65) begin
      put(symbols[$urandom_range(12)]);
    end else if (pick < 78) begin
      put(blank());
    end else if (pick < 88) begin
      put(8'($urandom_range(255)));
    end else if (pick < 93) begin
      put(8'h5f);
    end else begin
      // number running straight into a word
      put(digit());
      put(digit());
      put(letter());
      put(ident_char());
    end
    if ($urandom_range(99) < 55) put(blank());
  endtask

  task automatic run_text(int count);
    int stop;
    stop = sent + count;
    while (sent < stop) emit_token();
    send_byte(8'h20, 1'b1, 1'b0, '0);
  endtask

  task automatic long_run(bit digits, int len);
    int i;
    for (i = 0; i < len; i++) begin
      if (digits) send_byte(digit(), 1'b0, 1'b0, '0);
      else send_byte((i == 0) ? letter() : ident_char(), 1'b0, 1'b0, '0);
    end
    send_byte(blank(), 1'b0, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------- checks

  // Receiver stalls at random except during the calm stretch
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 38);
  end

  // Compare every accepted token with the oldest one owed
  always @(posedge clk) begin : check_tokens
    stt_pkg::out_res_t want;
    if (rst_n) begin
      cycles++;
      if (out_valid && !out_stall) begin
        if (awaited_tokens.size() == 0) begin
          report_mismatch("token with none owed", 1, 0);
        end else begin
          want = awaited_tokens.pop_front();
          if (out_res.token_kind !== want.token_kind)
            report_mismatch("token_kind", out_res.token_kind, want.token_kind);
          if (out_res.keyword_slot !== want.keyword_slot)
            report_mismatch("keyword_slot", out_res.keyword_slot, want.keyword_slot);
          if (out_res.token_length !== want.token_length)
            report_mismatch("token_length", out_res.token_length, want.token_length);
          if (out_res.length_overflow !== want.length_overflow)
            report_mismatch("length_overflow", out_res.length_overflow, want.length_overflow);
          if (out_res.first_char !== want.first_char)
            report_mismatch("first_char", out_res.first_char, want.first_char);
          if (out_res.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", out_res.last_of_run, want.last_of_run);
        end
      end
    end
  end

  initial begin
    while (cycles < Limit) @(posedge clk);
    $display("source_text_tokenizer_unit test failed");
    $finish;
  end

  // ---------------------------------------------------------------- main

  initial begin : stimulus
    logic [63:0] raw;
    int          i;

    // single-byte tokens and error bytes straight after reset
    directed.push_back(row(8'h00, 1'b1, 1'b1, tok(stt_pkg::KindError, 3'd0, 7'd1, 8'h00)));
    directed.push_back(row(8'hff, 1'b0, 1'b1, tok(stt_pkg::KindError, 3'd0, 7'd1, 8'hff)));
    directed.push_back(row(8'h80, 1'b0, 1'b1, tok(stt_pkg::KindError, 3'd0, 7'd1, 8'h80)));
    directed.push_back(row("+", 1'b0, 1'b1, tok(stt_pkg::KindOperator, 3'd0, 7'd1, "+")));
    directed.push_back(row(">", 1'b0, 1'b1, tok(stt_pkg::KindOperator, 3'd0, 7'd1, ">")));
    directed.push_back(row(";", 1'b0, 1'b1, tok(stt_pkg::KindPunct, 3'd0, 7'd1, ";")));
    directed.push_back(row("}", 1'b0, 1'b1, tok(stt_pkg::KindPunct, 3'd0, 7'd1, "}")));
    directed.push_back(row("_", 1'b0, 1'b1, tok(stt_pkg::KindError, 3'd0, 7'd1, "_")));
    directed.push_back(row(8'h08, 1'b0, 1'b1, tok(stt_pkg::KindError, 3'd0, 7'd1, 8'h08)));
    // end of text with nothing pending
    directed.push_back(row(" ", 1'b1, 1'b0, '0));
    // reset keyword in slot two, closed by a carriage return
    directed.push_back(row("i", 1'b0, 1'b0, '0));
    directed.push_back(row("f", 1'b0, 1'b0, '0));
    directed.push_back(row(8'h0d, 1'b0, 1'b1, tok(stt_pkg::KindKeyword, 3'd2, 7'd2, "i")));
    // number then letter, then a byte that closes and is a token itself
    directed.push_back(row("9", 1'b0, 1'b0, '0));
    directed.push_back(row("Z", 1'b0, 1'b0, '0));
    directed.push_back(row("0", 1'b0, 1'b0, '0));
    directed.push_back(row("(", 1'b0, 1'b0, '0));
    // underscore inside a word, flushed by end of text
    directed.push_back(row("a", 1'b0, 1'b0, '0));
    directed.push_back(row("_", 1'b0, 1'b0, '0));
    directed.push_back(row("z", 1'b1, 1'b0, '0));
    // number closed by punctuation that also ends the text
    directed.push_back(row("0", 1'b0, 1'b0, '0));
    directed.push_back(row("}", 1'b1, 1'b0, '0));
    directed.push_back(row(8'h0e, 1'b0, 1'b1, tok(stt_pkg::KindError, 3'd0, 7'd1, 8'h0e)));
    directed.push_back(row("A", 1'b1, 1'b0, '0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      send_byte(directed[i].b, directed[i].eot, directed[i].typed, directed[i].res);
    end
    settle();

    // reset keywords, with one identifier past the length limit
    run_text(60);
    long_run(1'b0, 128);
    settle();

    // random keywords, a duplicate slot and a disabled slot
    for (i = 0; i < stt_pkg::NumWords; i++) write_word(3'(i), make_word($urandom_range(1, 6)));
    write_word(3'd5, make_word(6));
    write_word(3'd3, kw_words[1]);
    write_word(3'd6, '0);
    run_text(60);
    settle();

    // all-ones words never match, slot zero off, unused index ignored
    for (i = 0; i < stt_pkg::NumWords; i++) write_word(3'(i), '1);
    write_word(3'd0, '0);
    raw = {$urandom(), $urandom()};
    write_word(3'd7, raw[47:0]);
    run_text(40);
    long_run(1'b1, 127);
    settle();

    // short keywords, no idling on either side
    calm = 1'b1;
    for (i = 0; i < stt_pkg::NumWords; i++) write_word(3'(i), make_word($urandom_range(1, 3)));
    run_text(60);
    settle();
    calm = 1'b0;

    // mix of raw and word-like keywords
    for (i = 0; i < stt_pkg::NumWords; i++) begin
      raw = {$urandom(), $urandom()};
      write_word(3'(i), (i % 2 == 1) ? raw[47:0] : make_word($urandom_range(1, 6)));
    end
    run_text(60);
    settle();

    repeat (16) @(posedge clk);
    if (awaited_tokens.size() != 0)
      report_mismatch("tokens never delivered", 0, awaited_tokens.size());
    if (errors == 0) begin
      $display("source_text_tokenizer_unit test passed");
    end else begin
      $display("source_text_tokenizer_unit test failed");
    end
    $finish;
  end

endmodule
